// ----- rtl/first_fit_block_allocator_core_assert.svh -----
// Assertion macros used by the checker file.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define FFBA_ASSERT_IMP(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");
// Implication checked in the cycle after the antecedent.
`define FFBA_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`endif

// ----- rtl/ffba_pkg.sv -----
// ----------------------------------------------------------------------------
// ffba_pkg
// Status codes, actions and register selects of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;
	localparam int OFFSET_BITS = 27;
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_ZERO    = 3'd1;
	localparam logic [2:0] ST_ARENA   = 3'd2;
	localparam logic [2:0] ST_TABLE   = 3'd3;
	localparam logic [2:0] ST_UNKNOWN = 3'd4;
	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;
	localparam logic REG_ARENA  = 1'b0;
	localparam logic REG_DOUBLE = 1'b1;
endpackage

// ----- rtl/ffba_ram.sv -----
// ----------------------------------------------------------------------------
// ffba_ram
// Generic single-port write, single-port read RAM with registered read data.
// ----------------------------------------------------------------------------
module ffba_ram #(
	parameter int WIDTH = 54,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- rtl/first_fit_block_allocator_core.sv -----
// ----------------------------------------------------------------------------
// first_fit_block_allocator_core
// First-fit allocator over one arena with an address-ordered block table.
// ----------------------------------------------------------------------------
// One word is handled at a time. The table sits in one RAM of start and length
// pairs read one entry per cycle. An allocate scans the table for the first
// fitting gap, reading each entry in S_RD and comparing it in S_CMP, and then
// shifts the upper entries up by one, each through S_MVRD and S_MVWR; a free
// scans for the match and shifts the rest down the same way. The result waits
// in an output register while the next word can already be taken.
module first_fit_block_allocator_core
	import ffba_pkg::*;
#(
	parameter int MAX_ENTRIES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic        s_tuser,   // action
	// request_size [25:0], free_offset [52:26], zero pad [55:53]
	input  logic [55:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// block_offset [26:0], status [29:27], zero pad [31:30]
	output logic [31:0] m_tdata
);
	localparam int AW = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int OB = OFFSET_BITS;
	localparam logic [OB-1:0] ARENA_RST = OB'(64'd104857600);

	typedef enum logic [3:0] {
		S_IDLE, S_RD, S_CMP, S_MVRD, S_MVWR, S_DONE
	} state_t;

	state_t          state_q;
	logic [OB-1:0]   arena_q;
	logic            dbl_q;
	logic [CW-1:0]   count_q;
	logic            act_q;
	logic [OB-1:0]   size_q;
	logic [OB-1:0]   where_q;
	logic [CW-1:0]   idx_q;
	logic [CW-1:0]   pos_q;
	logic [OB:0]     prev_end_q;
	logic            out_v_q;
	logic [OB-1:0]   out_off_q;
	logic [2:0]      out_st_q;
	logic [OB-1:0]   res_off_q;
	logic [2:0]      res_st_q;

	logic            we;
	logic [AW-1:0]   waddr, raddr;
	logic [2*OB-1:0] wdata, rdata;
	logic [OB-1:0]   r_start, r_len;
	logic [OB:0]     r_end, fit_end;
	logic            wr_cfg;
	logic            take;

	assign r_start = rdata[OB-1:0];
	assign r_len   = rdata[2*OB-1:OB];
	assign r_end   = {1'b0, r_start} + {1'b0, r_len};
	assign fit_end = prev_end_q + {1'b0, size_q};

	assign pready   = 1'b1;
	assign wr_cfg   = psel && penable && pwrite;
	assign prdata   = (paddr[2] == REG_DOUBLE) ? {31'd0, dbl_q} : 32'(arena_q);
	assign s_tready = (state_q == S_IDLE);
	assign take     = s_tvalid && s_tready;
	assign m_tvalid = out_v_q;
	assign m_tdata  = {2'd0, out_st_q, out_off_q};

	ffba_ram #(.WIDTH(2 * OB), .DEPTH(MAX_ENTRIES)) u_tbl (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	always_comb begin
		we    = 1'b0;
		waddr = idx_q[AW-1:0];
		wdata = rdata;
		raddr = idx_q[AW-1:0];
		if (state_q == S_MVRD && act_q == ACT_ALLOC) begin
			raddr = AW'(idx_q - CW'(1));
		end
		if (state_q == S_MVWR) begin
			we = 1'b1;
			if (act_q == ACT_ALLOC) begin
				if (idx_q == pos_q) begin
					wdata = {size_q, res_off_q};
				end
			end else begin
				waddr = AW'(idx_q - CW'(1));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			arena_q  <= ARENA_RST;
			dbl_q    <= 1'b1;
			count_q  <= '0;
			out_v_q  <= 1'b0;
		end else begin
			if (wr_cfg && paddr[2] == REG_ARENA) arena_q <= OB'(pwdata);
			if (wr_cfg && paddr[2] == REG_DOUBLE) dbl_q <= pwdata[0];
			if (state_q == S_DONE && (!out_v_q || m_tready)) out_v_q <= 1'b1;
			else if (m_tready) out_v_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (take) begin
						act_q   <= s_tuser;
						where_q <= OB'(s_tdata[52:26]);
						size_q  <= s_tuser == ACT_FREE ? '0 :
							(dbl_q ? OB'({s_tdata[25:0], 1'b0}) : OB'(s_tdata[25:0]));
						idx_q   <= '0;
						state_q <= S_RD;
					end
				end
				S_RD: begin
					if (act_q == ACT_ALLOC && size_q == '0) begin
						res_off_q <= '0; res_st_q <= ST_ZERO; state_q <= S_DONE;
					end else if (act_q == ACT_ALLOC && count_q == CW'(MAX_ENTRIES)) begin
						res_off_q <= '0; res_st_q <= ST_TABLE; state_q <= S_DONE;
					end else if (idx_q == count_q) begin
						if (act_q == ACT_FREE) begin
							res_off_q <= where_q; res_st_q <= ST_UNKNOWN;
							state_q <= S_DONE;
						end else begin
							if (count_q == '0) prev_end_q <= '0;
							state_q <= S_CMP;
						end
					end else begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (idx_q == count_q) begin
						if (fit_end > {1'b0, arena_q}) begin
							res_off_q <= '0; res_st_q <= ST_ARENA; state_q <= S_DONE;
						end else begin
							pos_q <= idx_q; res_off_q <= prev_end_q[OB-1:0];
							res_st_q <= ST_OK; state_q <= S_MVWR;
						end
					end else if (act_q == ACT_FREE) begin
						if (r_start == where_q) begin
							res_off_q <= where_q; res_st_q <= ST_OK;
							idx_q <= idx_q + CW'(1);
							state_q <= (idx_q + CW'(1) == count_q) ? S_DONE : S_MVRD;
							if (idx_q + CW'(1) == count_q) count_q <= count_q - CW'(1);
						end else begin
							idx_q <= idx_q + CW'(1); state_q <= S_RD;
						end
					end else begin
						prev_end_q <= r_end;
						if (idx_q != '0 && {1'b0, r_start} >= fit_end) begin
							pos_q <= idx_q; idx_q <= count_q;
							res_off_q <= prev_end_q[OB-1:0]; res_st_q <= ST_OK;
							state_q <= S_MVRD;
						end else begin
							idx_q <= idx_q + CW'(1); state_q <= S_RD;
						end
					end
				end
				S_MVRD: state_q <= S_MVWR;
				S_MVWR: begin
					if (act_q == ACT_ALLOC) begin
						if (idx_q == pos_q) begin
							count_q <= count_q + CW'(1); state_q <= S_DONE;
						end else begin
							idx_q <= idx_q - CW'(1); state_q <= S_MVRD;
						end
					end else if (idx_q + CW'(1) == count_q) begin
						count_q <= count_q - CW'(1); state_q <= S_DONE;
					end else begin
						idx_q <= idx_q + CW'(1); state_q <= S_MVRD;
					end
				end
				S_DONE: begin
					if (!out_v_q || m_tready) begin
						out_off_q <= res_off_q; out_st_q <= res_st_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- rtl/ffba_checker.sv -----
// ----------------------------------------------------------------------------
// ffba_checker
// Port-level checks on the allocator's result stream, input handshake and pready.
// ----------------------------------------------------------------------------
`include "first_fit_block_allocator_core_assert.svh"
module ffba_checker
	import ffba_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        pready
);
	`FFBA_ASSERT_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`FFBA_ASSERT_IMP(a_status, clk, arst_n, m_tvalid, m_tdata[29:27] <= ST_UNKNOWN)
	`FFBA_ASSERT_IMP(a_fail_zero, clk, arst_n,
		m_tvalid && (m_tdata[29:27] == ST_ZERO || m_tdata[29:27] == ST_TABLE ||
		m_tdata[29:27] == ST_ARENA), m_tdata[26:0] == 27'd0)
	`FFBA_ASSERT_NEXT(a_one, clk, arst_n, s_tvalid && s_tready, !s_tready)
	`FFBA_ASSERT_IMP(a_pready, clk, arst_n, 1'b1, pready)
endmodule

bind first_fit_block_allocator_core ffba_checker u_ffba_checker (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .pready(pready)
);

// ----- dv/first_fit_block_allocator_core_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// first_fit_block_allocator_core_test
// Stream test of the first-fit allocator against a predictor of its table.
// ----------------------------------------------------------------------------
// Allocate and free words are sent with random gaps; each result word is
// compared with the offset and status that a copy of the block table predicts.
module first_fit_block_allocator_core_test;
	import ffba_pkg::*;

	localparam int TABLE_DEPTH = 256;

	typedef struct packed {
		logic [26:0] offset;
		logic [2:0]  status;
	} alloc_result_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid;
	logic        s_tready;
	logic        s_tuser;
	logic [55:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;

	logic [26:0]   arena_size;
	logic          double_on;
	logic [26:0]   blk_start[TABLE_DEPTH];
	logic [26:0]   blk_length[TABLE_DEPTH];
	int            blk_count;
	alloc_result_t pending_results[$];
	logic [26:0]   live_offsets[$];
	int            failures;
	bit            stall_enable;

	first_fit_block_allocator_core uut (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic void insert_block(int pos, logic [26:0] start, logic [26:0] len);
		for (int k = blk_count; k > pos; k--) begin
			blk_start[k] = blk_start[k - 1];
			blk_length[k] = blk_length[k - 1];
		end
		blk_start[pos] = start;
		blk_length[pos] = len;
		blk_count++;
	endfunction

	function automatic alloc_result_t predict_word(logic act, logic [25:0] req,
			logic [26:0] where);
		alloc_result_t r;
		logic [27:0] size;
		logic [27:0] prev_end;
		logic [27:0] gap;
		r.offset = (act == ACT_FREE) ? where : 27'd0;
		if (act == ACT_FREE) begin
			r.status = ST_UNKNOWN;
			for (int i = 0; i < blk_count; i++) begin
				if (blk_start[i] == where) begin
					for (int k = i; k + 1 < blk_count; k++) begin
						blk_start[k] = blk_start[k + 1];
						blk_length[k] = blk_length[k + 1];
					end
					blk_count--;
					r.status = ST_OK;
					break;
				end
			end
			return r;
		end
		size = double_on ? {1'b0, req, 1'b0} : {2'b0, req};
		if (size == 0) begin
			r.status = ST_ZERO;
			return r;
		end
		if (blk_count >= TABLE_DEPTH) begin
			r.status = ST_TABLE;
			return r;
		end
		for (int i = 1; i < blk_count; i++) begin
			prev_end = blk_start[i - 1] + blk_length[i - 1];
			gap = (blk_start[i] > prev_end) ? blk_start[i] - prev_end : 28'd0;
			if (gap >= size) begin
				insert_block(i, prev_end[26:0], size[26:0]);
				r.offset = prev_end[26:0];
				r.status = ST_OK;
				return r;
			end
		end
		prev_end = (blk_count > 0) ?
			{1'b0, blk_start[blk_count - 1]} + blk_length[blk_count - 1] : 28'd0;
		if (prev_end + size > {1'b0, arena_size}) begin
			r.status = ST_ARENA;
			return r;
		end
		insert_block(blk_count, prev_end[26:0], size[26:0]);
		r.offset = prev_end[26:0];
		r.status = ST_OK;
		return r;
	endfunction

	task automatic idle_cycles();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0)
			n = 0;
		repeat (n + 1) @(posedge clk);
	endtask

	task automatic send_word(logic act, logic [25:0] req, logic [26:0] where);
		alloc_result_t r;
		idle_cycles();
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {3'b0, where, req};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		r = predict_word(act, req, where);
		pending_results.push_back(r);
		if (act == ACT_ALLOC && r.status == ST_OK)
			live_offsets.push_back(r.offset);
		if (act == ACT_FREE && r.status == ST_OK) begin
			foreach (live_offsets[i]) begin
				if (live_offsets[i] == where) begin
					live_offsets.delete(i);
					break;
				end
			end
		end
		s_tvalid <= 1'b0;
	endtask

	task automatic drain();
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (900) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] addr, logic [31:0] value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == 3'd0)
			arena_size = value[26:0];
		else
			double_on = value[0];
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected word %h", $time, m_tdata);
				failures++;
			end else begin
				alloc_result_t e;
				e = pending_results.pop_front();
				if (m_tdata[26:0] !== e.offset) begin
					$display("%0t: offset expected %h actual %h", $time, e.offset,
						m_tdata[26:0]);
					failures++;
				end
				if (m_tdata[29:27] !== e.status) begin
					$display("%0t: status expected %0d actual %0d", $time, e.status,
						m_tdata[29:27]);
					failures++;
				end
			end
		end
		m_tready <= stall_enable ? ($urandom_range(0, 3) != 0) : 1'b1;
	end

	task automatic test_directed();
		write_reg(3'd4, 32'd0);
		write_reg(3'd0, 32'd1000);
		send_word(ACT_ALLOC, 26'd0, 27'h7FFFFFF);
		send_word(ACT_FREE, 26'h3FFFFFF, 27'd0);
		send_word(ACT_ALLOC, 26'd100, 27'd0);
		send_word(ACT_ALLOC, 26'd200, 27'd0);
		send_word(ACT_ALLOC, 26'd300, 27'd0);
		send_word(ACT_ALLOC, 26'd500, 27'd0);
		send_word(ACT_ALLOC, 26'h3FFFFFF, 27'd0);
		send_word(ACT_FREE, 26'd0, 27'd100);
		send_word(ACT_ALLOC, 26'd250, 27'd0);
		send_word(ACT_ALLOC, 26'd200, 27'd0);
		send_word(ACT_FREE, 26'd0, 27'd0);
		send_word(ACT_ALLOC, 26'd50, 27'd0);
		send_word(ACT_FREE, 26'd0, 27'h7FFFFFF);
		send_word(ACT_FREE, 26'd0, 27'd12345);
		drain();
		write_reg(3'd0, 32'd1);
		send_word(ACT_ALLOC, 26'd1, 27'd0);
		drain();
		write_reg(3'd0, 32'h7FFFFFF);
		write_reg(3'd4, 32'd1);
		send_word(ACT_ALLOC, 26'h3FFFFFF, 27'd0);
		send_word(ACT_ALLOC, 26'h3FFFFFF, 27'd0);
		drain();
	endtask

	task automatic test_table_full();
		write_reg(3'd4, 32'd0);
		for (int i = 0; i < TABLE_DEPTH + 3; i++)
			send_word(ACT_ALLOC, 26'($urandom_range(1, 3)), 27'd0);
		send_word(ACT_ALLOC, 26'd0, 27'd0);
		while (live_offsets.size() > TABLE_DEPTH - 64)
			send_word(ACT_FREE, 26'($urandom), live_offsets[$urandom_range(0,
				live_offsets.size() - 1)]);
		drain();
	endtask

	task automatic random_phase(int count, logic [26:0] arena, bit dbl);
		logic [26:0] where;
		write_reg(3'd0, {5'b0, arena});
		write_reg(3'd4, {31'b0, dbl});
		for (int i = 0; i < count; i++) begin
			if (i == count / 2) begin
				while (pending_results.size() != 0)
					@(posedge clk);
			end
			if ($urandom_range(0, 9) < 5 || live_offsets.size() == 0) begin
				if ($urandom_range(0, 15) == 0)
					send_word(ACT_ALLOC, 26'($urandom), 27'($urandom));
				else
					send_word(ACT_ALLOC, 26'($urandom_range(0, 5000)), 27'($urandom));
			end else begin
				where = ($urandom_range(0, 7) == 0) ? 27'($urandom) :
					live_offsets[$urandom_range(0, live_offsets.size() - 1)];
				send_word(ACT_FREE, 26'($urandom), where);
			end
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = 3'd0;
		pwdata = 32'd0;
		s_tvalid = 1'b0;
		s_tuser = 1'b0;
		s_tdata = 56'd0;
		m_tready = 1'b1;
		stall_enable = 1'b0;
		failures = 0;
		blk_count = 0;
		arena_size = 27'd104857600;
		double_on = 1'b1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		stall_enable = 1'b1;
		test_table_full();
		random_phase(40, 27'd100000, 1'b1);
		random_phase(35, 27'd20000, 1'b0);
		stall_enable = 1'b0;
		random_phase(35, 27'h7FFFFFF, 1'b1);
		if (failures == 0)
			$display("first_fit_block_allocator_core: match");
		else
			$display("first_fit_block_allocator_core: mismatch");
		$finish;
	end

	initial begin
		#20ms;
		$display("first_fit_block_allocator_core: mismatch");
		$finish;
	end
endmodule
